// ===== hw/rtl/ptcdt_pkg.sv =====
// ============================================================================
// ptcdt_pkg: shared types and constants of the divider thermistor block
// Holds the resistance/temperature ROM, the register indexes and the
// command and status groups between controller and datapath.
// ============================================================================
package ptcdt_pkg;

    localparam int TABLE_POINTS = 20;
    localparam int SEG_W        = $clog2(TABLE_POINTS);
    localparam int OHM_W        = 13;
    localparam int DEG_W        = 9;
    localparam int TEMP_W       = 13;
    localparam int NUM_W        = 24;
    localparam int CNT_W        = 5;

    localparam logic signed [TEMP_W-1:0] FAULT_TEMP = -13'sd3000;

    typedef enum logic [1:0] {
        REG_SUPPLY  = 2'd0,
        REG_SERIES  = 2'd1,
        REG_HOLDOFF = 2'd2
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_load;
        logic div_step;
        logic range_chk;
        logic seg_step;
        logic interp;
        logic scale;
        logic finish;
        logic fault_eval;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sense_ok;
        logic div_last;
        logic in_range;
        logic seg_done;
        logic emit;
    } status_t;

    // resistance points in ohms, ascending
    function automatic logic [OHM_W-1:0] rom_ohms(input logic [SEG_W-1:0] idx);
        logic [OHM_W-1:0] v;
        unique case (idx)
            0:       v = 13'd1135;
            1:       v = 13'd1247;
            2:       v = 13'd1396;
            3:       v = 13'd1495;
            4:       v = 13'd1630;
            5:       v = 13'd1772;
            6:       v = 13'd1922;
            7:       v = 13'd2000;
            8:       v = 13'd2080;
            9:       v = 13'd2245;
            10:      v = 13'd2417;
            11:      v = 13'd2597;
            12:      v = 13'd2785;
            13:      v = 13'd2980;
            14:      v = 13'd3118;
            15:      v = 13'd3392;
            16:      v = 13'd3817;
            17:      v = 13'd4008;
            18:      v = 13'd4166;
            19:      v = 13'd4280;
            default: v = 13'd4280;
        endcase
        return v;
    endfunction

    // temperature points in whole degrees C
    function automatic logic signed [DEG_W-1:0] rom_deg(input logic [SEG_W-1:0] idx);
        logic signed [DEG_W-1:0] v;
        unique case (idx)
            0:       v = -9'sd40;
            1:       v = -9'sd30;
            2:       v = -9'sd20;
            3:       v = -9'sd10;
            4:       v = 9'sd0;
            5:       v = 9'sd10;
            6:       v = 9'sd20;
            7:       v = 9'sd25;
            8:       v = 9'sd30;
            9:       v = 9'sd40;
            10:      v = 9'sd50;
            11:      v = 9'sd60;
            12:      v = 9'sd70;
            13:      v = 9'sd80;
            14:      v = 9'sd90;
            15:      v = 9'sd100;
            16:      v = 9'sd110;
            17:      v = 9'sd120;
            18:      v = 9'sd130;
            19:      v = 9'sd140;
            default: v = 9'sd140;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ptcdt_dp.sv =====
// ============================================================================
// ptcdt_dp: datapath of the divider thermistor block
// Product, shared restoring divider, segment search, interpolation and
// fault hold-off timer, each step started by a controller command.
// ============================================================================
module ptcdt_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ptcdt_pkg::cmd_t                       cmd,
    output ptcdt_pkg::status_t                    status,
    input  logic [15:0]                           in_sense,
    input  logic [31:0]                           in_now,
    input  logic [15:0]                           supply,
    input  logic [15:0]                           series,
    input  logic [15:0]                           holdoff,
    output logic signed [ptcdt_pkg::TEMP_W-1:0]   res_temp,
    output logic                                  res_fault
);
    import ptcdt_pkg::*;

    logic [15:0]              sense_reg;
    logic [31:0]              now_reg;
    logic [31:0]              prod_reg;
    logic [31:0]              dvd_reg;
    logic [31:0]              dvd_next;
    logic [15:0]              rem_reg;
    logic [15:0]              rem_next;
    logic [15:0]              dsr_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [OHM_W-1:0]         r_reg;
    logic [SEG_W-1:0]         seg_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     fault_reg;
    logic                     emit_reg;
    logic                     pending_reg;
    logic [31:0]              start_reg;

    logic [16:0]              trial;
    logic [16:0]              diff;
    logic                     ge;
    logic [SEG_W-1:0]         seg_up;
    logic [OHM_W-1:0]         ohm_lo;
    logic [OHM_W-1:0]         ohm_hi;
    logic [OHM_W-1:0]         seg_d;
    logic [OHM_W-1:0]         seg_dr;
    logic signed [NUM_W-1:0]  d_s;
    logic signed [NUM_W-1:0]  dr_s;
    logic signed [NUM_W-1:0]  deg_lo_s;
    logic signed [NUM_W-1:0]  ddeg_s;
    logic signed [NUM_W-1:0]  num_calc;
    logic signed [NUM_W-1:0]  num10;
    logic signed [NUM_W-1:0]  mag;
    logic [31:0]              base;
    logic [31:0]              elapsed;

    // one restoring divider step
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        ge       = trial >= {1'b0, dsr_reg};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = ge ? diff[15:0] : trial[15:0];
        dvd_next = {dvd_reg[30:0], ge};
    end

    // segment bounds and interpolation numerator
    always_comb
    begin
        seg_up   = SEG_W'(seg_reg + 1'b1);
        ohm_lo   = rom_ohms(seg_reg);
        ohm_hi   = rom_ohms(seg_up);
        seg_d    = ohm_hi - ohm_lo;
        seg_dr   = r_reg - ohm_lo;
        d_s      = $signed(NUM_W'(seg_d));
        dr_s     = $signed(NUM_W'(seg_dr));
        deg_lo_s = NUM_W'(rom_deg(seg_reg));
        ddeg_s   = NUM_W'(rom_deg(seg_up)) - NUM_W'(rom_deg(seg_reg));
        num_calc = deg_lo_s * d_s + dr_s * ddeg_s;
        num10    = (num_reg <<< 3) + (num_reg <<< 1);
        mag      = num_reg[NUM_W-1] ? -num10 : num10;
    end

    always_comb
    begin
        base    = pending_reg ? start_reg : now_reg;
        elapsed = now_reg - base;
    end

    always_comb
    begin
        status.sense_ok = (sense_reg != 16'd0) && (sense_reg < supply);
        status.div_last = &cnt_reg;
        status.in_range = (dvd_reg >= 32'(rom_ohms(SEG_W'(0))))
                       && (dvd_reg <= 32'(rom_ohms(SEG_W'(TABLE_POINTS - 1))));
        status.seg_done = !((seg_reg < SEG_W'(TABLE_POINTS - 2)) && (r_reg > ohm_hi));
        status.emit     = emit_reg;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sense_reg <= in_sense;
            now_reg   <= in_now;
        end
        if (cmd.prep)
        begin
            prod_reg <= 32'(series) * 32'(16'(supply - sense_reg));
        end
        if (cmd.div_load)
        begin
            dvd_reg <= prod_reg;
            dsr_reg <= sense_reg;
            rem_reg <= '0;
        end
        else if (cmd.scale)
        begin
            dvd_reg <= 32'($unsigned(mag));
            dsr_reg <= 16'(seg_d);
            rem_reg <= '0;
            neg_reg <= num_reg[NUM_W-1];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.range_chk)
        begin
            r_reg   <= dvd_reg[OHM_W-1:0];
            seg_reg <= '0;
        end
        else if (cmd.seg_step)
        begin
            seg_reg <= seg_up;
        end
        if (cmd.interp)
        begin
            num_reg <= num_calc;
        end
        if (cmd.finish)
        begin
            temp_reg  <= neg_reg ? -$signed(dvd_reg[TEMP_W-1:0])
                                 : $signed(dvd_reg[TEMP_W-1:0]);
            fault_reg <= 1'b0;
        end
        else if (cmd.fault_eval)
        begin
            temp_reg  <= FAULT_TEMP;
            fault_reg <= 1'b1;
        end
    end

    // control and fault timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            emit_reg    <= 1'b0;
            pending_reg <= 1'b0;
            start_reg   <= '0;
        end
        else
        begin
            if (cmd.div_load || cmd.scale)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
            if (cmd.finish)
            begin
                emit_reg    <= 1'b1;
                pending_reg <= 1'b0;
                start_reg   <= '0;
            end
            else if (cmd.fault_eval)
            begin
                emit_reg    <= elapsed >= {16'd0, holdoff};
                pending_reg <= 1'b1;
                start_reg   <= base;
            end
        end
    end

    assign res_temp  = temp_reg;
    assign res_fault = fault_reg;

    a_cnt_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && status.div_last && !cmd.div_load && !cmd.scale |=> cnt_reg == '0)
        else $error("divider count did not wrap after last step");

    a_zero_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fault_eval && !cmd.finish && holdoff == 16'd0 |=> emit_reg)
        else $error("zero hold-off must report the fault at once");

endmodule

// ===== hw/rtl/ptcdt_ctrl.sv =====
// ============================================================================
// ptcdt_ctrl: sequencer of the divider thermistor block
// One-hot state machine that steps one sample through the datapath.
// ============================================================================
module ptcdt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 push,
    output ptcdt_pkg::cmd_t      cmd,
    input  ptcdt_pkg::status_t   status
);
    import ptcdt_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_PREP   = 12'b0000_0000_0010,
        ST_LOAD   = 12'b0000_0000_0100,
        ST_DIV1   = 12'b0000_0000_1000,
        ST_RANGE  = 12'b0000_0001_0000,
        ST_SEARCH = 12'b0000_0010_0000,
        ST_INTERP = 12'b0000_0100_0000,
        ST_SCALE  = 12'b0000_1000_0000,
        ST_DIV2   = 12'b0001_0000_0000,
        ST_FINISH = 12'b0010_0000_0000,
        ST_FAULT  = 12'b0100_0000_0000,
        ST_EMIT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.sense_ok)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV1;
                end
                else
                begin
                    state_next = ST_FAULT;
                end
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                cmd.range_chk = 1'b1;
                state_next    = status.in_range ? ST_SEARCH : ST_FAULT;
            end
            ST_SEARCH:
            begin
                if (status.seg_done)
                    state_next = ST_INTERP;
                else
                    cmd.seg_step = 1'b1;
            end
            ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_FAULT:
            begin
                cmd.fault_eval = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/silicon_ptc_divider_temperature.sv =====
// ============================================================================
// silicon_ptc_divider_temperature: divider sensor to temperature converter
// Turns a millivolt sample across the series resistor into sensor ohms,
// then into tenths of a degree by piecewise linear lookup, with a
// hold-off timer before an out-of-range sensor is reported as faulted.
// ============================================================================
//
//  channel   direction  transaction                           fields (low bit up)
//  s_axis    in         one sample                            sense_millivolts, now_ms
//  m_axis    out        zero or one result per sample         temp_decidegrees; tuser fault
//  apb       in         register write/read at 4*index        supply, series, holdoff
//
//  A zero sample or one at/above supply goes straight to the fault state; a
//  resistance outside the table faults after the first division; an in-range
//  sample finds its table segment (0..18) and interpolates. The shared 32-step
//  restoring divider runs once for ohms and once for the interpolation quotient.
//  Reset (rst_n low, asynchronous) restores the register defaults, clears
//  the fault timer and empties the output register.
//  A stalled output holds the result; the next sample is taken while it
//  waits and its own result waits in the final state until the slot frees.
// ============================================================================
module silicon_ptc_divider_temperature
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [15:0] sense_millivolts, [47:16] now_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // m_tdata: [12:0] temp_decidegrees (signed), [15:13] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // m_tuser: [0] sensor_fault
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptcdt_pkg::*;

    logic [15:0]              supply_reg;
    logic [15:0]              series_reg;
    logic [15:0]              holdoff_reg;
    reg_idx_t                 reg_idx;
    logic                     wr_en;

    logic                     m_tvalid_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;
    logic                     fault_out_reg;

    cmd_t                     cmd;
    status_t                  status;
    logic                     push;
    logic                     out_free;
    logic signed [TEMP_W-1:0] res_temp;
    logic                     res_fault;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg  <= 16'd3300;
            series_reg  <= 16'd2000;
            holdoff_reg <= 16'd5000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SUPPLY:  supply_reg  <= pwdata[15:0];
                REG_SERIES:  series_reg  <= pwdata[15:0];
                REG_HOLDOFF: holdoff_reg <= pwdata[15:0];
                default:     ;  // unmapped address, drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SUPPLY:  prdata = {16'd0, supply_reg};
            REG_SERIES:  prdata = {16'd0, series_reg};
            REG_HOLDOFF: prdata = {16'd0, holdoff_reg};
            default:     prdata = '0;
        endcase
    end

    ptcdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .push     (push),
        .cmd      (cmd),
        .status   (status)
    );

    ptcdt_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_sense  (s_tdata[15:0]),
        .in_now    (s_tdata[47:16]),
        .supply    (supply_reg),
        .series    (series_reg),
        .holdoff   (holdoff_reg),
        .res_temp  (res_temp),
        .res_fault (res_fault)
    );

    // output register: free when empty or draining this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (push)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            temp_out_reg  <= res_temp;
            fault_out_reg <= res_fault;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, temp_out_reg};
    assign m_tuser  = fault_out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over a held transaction");

    a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata[12:0]) == FAULT_TEMP)
        else $error("fault transaction without the fault temperature");

    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> ($signed(m_tdata[12:0]) >= -13'sd400)
                              && ($signed(m_tdata[12:0]) <= 13'sd1400))
        else $error("normal temperature outside the table span");

endmodule
